[src/m4inv_pkg.sv]
package m4inv_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned ROW_W = 2;
  // 3x3 minor of 32-bit values: 96 bits + growth; cofactor 99, det 133 bits
  localparam int unsigned COF_W = 100;
  localparam int unsigned DET_W = 134;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_COF,
    ST_DET,
    ST_DIV,
    ST_EMIT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       store_row;
    logic       cof_step;
    logic       cof_clear;
    logic       det_step;
    logic       div_start;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic cof_done;
    logic det_done;
    logic div_done;
  } sts_t;

  // row or column index of the 3x3 minor excluding index j, position k
  function automatic logic [1:0] skip_idx(input logic [1:0] j, input logic [1:0] k);
    skip_idx = (k < j) ? k : k + 2'd1;
  endfunction

endpackage

[src/m4inv_if.sv]
interface m4inv_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  row_index;
  logic signed [31:0] col0;
  logic signed [31:0] col1;
  logic signed [31:0] col2;
  logic signed [31:0] col3;
  modport source (output valid, row_index, col0, col1, col2, col3, input ready);
  modport sink (input valid, row_index, col0, col1, col2, col3, output ready);
endinterface

interface m4inv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_row;
  logic signed [31:0] out0;
  logic signed [31:0] out1;
  logic signed [31:0] out2;
  logic signed [31:0] out3;
  logic        singular;
  logic        last;
  modport source (output valid, out_row, out0, out1, out2, out3, singular, last,
                  input ready);
  modport sink (input valid, out_row, out0, out1, out2, out3, singular, last,
                output ready);
endinterface

[src/matrix4x4_inverse.sv]
// Channel  | Dir | Fields
// in_      | in  | row_index, col0..col3 (Q16.16)
// out_     | out | out_row, out0..out3, singular, last
//
// Rows 0..2 are taken while idle. Row 3 starts a run: 16 cofactors on one
// shared 33x33 multiplier, the determinant (four limbs per column), then per
// element one restoring divider pass (start, 166 quotient bits, capture),
// and a result row after every fourth element; most of a run is spent in
// the divider.
// Reset (rst_n, synchronous) clears the matrix store and the controller.
// in_ready is low for the whole run; a result row holds while out_ready is low.
module matrix4x4_inverse #(
  parameter int unsigned FRAC_BITS = m4inv_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  m4inv_in_if.sink    in_ch,
  m4inv_out_if.source out_ch
);

  m4inv_pkg::cmd_t cmd;
  m4inv_pkg::sts_t sts;
  logic [1:0] emit_row;
  logic [3:0] elem_idx;
  logic       sing;

  m4inv_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid (in_ch.valid),
    .in_row   (in_ch.row_index),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .emit_row, .elem_idx, .cmd, .sts
  );

  m4inv_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n,
    .in_row (in_ch.row_index),
    .in_c0  (in_ch.col0),
    .in_c1  (in_ch.col1),
    .in_c2  (in_ch.col2),
    .in_c3  (in_ch.col3),
    .elem_idx, .cmd, .sts,
    .res0   (out_ch.out0),
    .res1   (out_ch.out1),
    .res2   (out_ch.out2),
    .res3   (out_ch.out3),
    .sing
  );

  assign out_ch.out_row  = emit_row;
  assign out_ch.singular = sing;
  assign out_ch.last     = (emit_row == 2'd3);

endmodule

[src/m4inv_ctrl.sv]
module m4inv_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_row,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            emit_row,
  output logic [3:0]            elem_idx,
  output m4inv_pkg::cmd_t       cmd,
  input  m4inv_pkg::sts_t       sts
);

  m4inv_pkg::state_t state_r, state_nxt;
  logic [3:0] elem_r, elem_nxt;
  logic       busy_r, busy_nxt;

  assign elem_idx = elem_r;
  assign emit_row = elem_r[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= m4inv_pkg::ST_LOAD;
      elem_r  <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      elem_r  <= elem_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    elem_nxt  = elem_r;
    busy_nxt  = 1'b0;
    unique case (state_r)
      m4inv_pkg::ST_LOAD: begin
        elem_nxt = '0;
        if (in_valid && in_row == 2'd3) state_nxt = m4inv_pkg::ST_COF;
      end
      m4inv_pkg::ST_COF: begin
        if (sts.cof_done) begin
          if (elem_r == 4'd15) begin
            state_nxt = m4inv_pkg::ST_DET;
            elem_nxt  = '0;
          end else begin
            elem_nxt = elem_r + 4'd1;
          end
        end
      end
      m4inv_pkg::ST_DET: begin
        if (sts.det_done) begin
          state_nxt = m4inv_pkg::ST_DIV;
          elem_nxt  = '0;
        end
      end
      m4inv_pkg::ST_DIV: begin
        busy_nxt = 1'b1;
        if (busy_r && sts.div_done) begin
          busy_nxt = 1'b0;
          if (elem_r[1:0] == 2'd3) state_nxt = m4inv_pkg::ST_EMIT;
          else elem_nxt = elem_r + 4'd1;
        end
      end
      m4inv_pkg::ST_EMIT: begin
        if (out_ready) begin
          if (elem_r == 4'd15) begin
            state_nxt = m4inv_pkg::ST_LOAD;
          end else begin
            state_nxt = m4inv_pkg::ST_DIV;
            elem_nxt  = elem_r + 4'd1;
          end
        end
      end
      default: state_nxt = m4inv_pkg::ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      m4inv_pkg::ST_LOAD: begin
        in_ready      = 1'b1;
        cmd.store_row = in_valid;
        cmd.cof_clear = 1'b1;
      end
      m4inv_pkg::ST_COF: cmd.cof_step = 1'b1;
      m4inv_pkg::ST_DET: cmd.det_step = 1'b1;
      m4inv_pkg::ST_DIV: begin
        cmd.div_start = !busy_r;
        cmd.div_step  = busy_r;
        cmd.out_load  = busy_r && sts.div_done;
      end
      m4inv_pkg::ST_EMIT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

[src/m4inv_dp.sv]
module m4inv_dp #(
  parameter int unsigned FRAC_BITS = m4inv_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_row,
  input  logic [31:0]           in_c0,
  input  logic [31:0]           in_c1,
  input  logic [31:0]           in_c2,
  input  logic [31:0]           in_c3,
  input  logic [3:0]            elem_idx,
  input  m4inv_pkg::cmd_t       cmd,
  output m4inv_pkg::sts_t       sts,
  output logic [31:0]           res0,
  output logic [31:0]           res1,
  output logic [31:0]           res2,
  output logic [31:0]           res3,
  output logic                  sing
);

  localparam int unsigned CW = m4inv_pkg::COF_W;
  localparam int unsigned DW = m4inv_pkg::DET_W;
  localparam int unsigned NW = DW + 2 * FRAC_BITS;       // numerator width
  localparam int unsigned CNT_W = $clog2(NW + 1);
  localparam logic [CNT_W-1:0] NW_C = CNT_W'(NW);

  logic [31:0] m_r [16];
  logic signed [CW-1:0] cof_r [16];
  logic signed [DW-1:0] det_r;

  logic cof_done;
  logic det_done;
  logic div_done;

  assign sts = {cof_done, det_done, div_done};

  // ---------- matrix store ----------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) m_r[i] <= '0;
    end else if (cmd.store_row) begin
      m_r[{in_row, 2'd0}] <= in_c0;
      m_r[{in_row, 2'd1}] <= in_c1;
      m_r[{in_row, 2'd2}] <= in_c2;
      m_r[{in_row, 2'd3}] <= in_c3;
    end
  end

  // cofactor unit: triple products built in phases on the shared multiplier
  // term t (0..5) walks the permutations of the 3x3 minor.
  // phase 0: a*b; phase 1: low half of (a*b) times c; phase 2: high half times c.
  logic [2:0]  term_r, term_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [63:0] p1_r;
  logic signed [CW-1:0] acc_r, acc_nxt;
  logic signed [CW-1:0] part;
  logic [1:0] ci, cj, r0, r1, r2, pa, pb, pc;
  logic       tneg;
  logic [31:0] ma, mb, mc;
  logic signed [32:0] mul_x, mul_y;
  logic signed [65:0] mul_p;

  assign ci = elem_idx[3:2];
  assign cj = elem_idx[1:0];
  assign r0 = m4inv_pkg::skip_idx(ci, 2'd0);
  assign r1 = m4inv_pkg::skip_idx(ci, 2'd1);
  assign r2 = m4inv_pkg::skip_idx(ci, 2'd2);

  always_comb begin
    pa = 2'd0; pb = 2'd1; pc = 2'd2; tneg = 1'b0;
    case (term_r)
      3'd0: begin pa = 2'd0; pb = 2'd1; pc = 2'd2; tneg = 1'b0; end
      3'd1: begin pa = 2'd0; pb = 2'd2; pc = 2'd1; tneg = 1'b1; end
      3'd2: begin pa = 2'd1; pb = 2'd0; pc = 2'd2; tneg = 1'b1; end
      3'd3: begin pa = 2'd1; pb = 2'd2; pc = 2'd0; tneg = 1'b0; end
      3'd4: begin pa = 2'd2; pb = 2'd0; pc = 2'd1; tneg = 1'b0; end
      default: begin pa = 2'd2; pb = 2'd1; pc = 2'd0; tneg = 1'b1; end
    endcase
  end

  assign ma = m_r[{r0, m4inv_pkg::skip_idx(cj, pa)}];
  assign mb = m_r[{r1, m4inv_pkg::skip_idx(cj, pb)}];
  assign mc = m_r[{r2, m4inv_pkg::skip_idx(cj, pc)}];

  // determinant pass reuses the same multiplier: cof[c] * m[c], one 32-bit limb a cycle
  logic [1:0]   dcol_r, dcol_nxt;
  logic [1:0]   dchk_r, dchk_nxt;
  logic [127:0] dcof;
  logic [31:0]  dlimb;
  logic [31:0]  dm;
  logic signed [DW-1:0] dpart;

  assign dcof = 128'(cof_r[{2'd0, dcol_r}]);
  assign dm   = m_r[{2'd0, dcol_r}];

  always_comb begin
    case (dchk_r)
      2'd0: dlimb = dcof[31:0];
      2'd1: dlimb = dcof[63:32];
      2'd2: dlimb = dcof[95:64];
      default: dlimb = dcof[127:96];
    endcase
  end

  // 33x33 signed multiplier; lower limbs enter zero-extended, top limbs sign-extended
  always_comb begin
    if (cmd.det_step) begin
      mul_x = (dchk_r == 2'd3) ? {dlimb[31], dlimb} : {1'b0, dlimb};
      mul_y = {dm[31], dm};
    end else begin
      case (ph_r)
        2'd0: begin
          mul_x = {ma[31], ma};
          mul_y = {mb[31], mb};
        end
        2'd1: begin
          mul_x = {1'b0, p1_r[31:0]};
          mul_y = {mc[31], mc};
        end
        default: begin
          mul_x = {p1_r[63], p1_r[63:32]};
          mul_y = {mc[31], mc};
        end
      endcase
    end
  end

  assign mul_p = mul_x * mul_y;
  assign dpart = DW'(mul_p) << {dchk_r, 5'd0};

  always_comb begin
    term_nxt = term_r;
    ph_nxt   = ph_r;
    acc_nxt  = acc_r;
    cof_done = 1'b0;
    part     = (ph_r == 2'd1) ? CW'(mul_p) : (CW'(mul_p) <<< 32);
    if (cmd.cof_step) begin
      if (ph_r == 2'd0) begin
        ph_nxt = 2'd1;
      end else begin
        acc_nxt = tneg ? acc_r - part : acc_r + part;
        if (ph_r == 2'd1) begin
          ph_nxt = 2'd2;
        end else begin
          ph_nxt = 2'd0;
          if (term_r == 3'd5) begin
            term_nxt = '0;
            cof_done = 1'b1;
          end else begin
            term_nxt = term_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cof_clear) begin
      term_r <= '0;
      ph_r   <= '0;
      acc_r  <= '0;
    end else begin
      term_r <= term_nxt;
      ph_r   <= ph_nxt;
      acc_r  <= cof_done ? '0 : acc_nxt;
    end
    if (cmd.cof_step && ph_r == 2'd0) p1_r <= mul_p[63:0];
    if (cof_done) cof_r[elem_idx] <= (ci[0] ^ cj[0]) ? -acc_nxt : acc_nxt;
  end

  // determinant: four limbs per column
  always_comb begin
    dcol_nxt = dcol_r;
    dchk_nxt = dchk_r;
    det_done = 1'b0;
    if (cmd.det_step) begin
      dchk_nxt = dchk_r + 2'd1;
      if (dchk_r == 2'd3) begin
        dcol_nxt = dcol_r + 2'd1;
        det_done = (dcol_r == 2'd3);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.cof_clear) begin
      dcol_r <= '0;
      dchk_r <= '0;
      det_r  <= '0;
    end else begin
      dcol_r <= dcol_nxt;
      dchk_r <= dchk_nxt;
      if (cmd.det_step) det_r <= det_r + dpart;
    end
  end

  // ---------- restoring divider, one quotient bit per cycle ----------
  logic [NW-1:0] num_r;
  logic [DW-1:0] rem_r, den_abs;
  logic [NW-1:0] q_r;
  logic [CNT_W-1:0] cnt_r;
  logic          qneg_r;
  logic [DW:0]   rem_sh, rem_sub;
  logic signed [CW-1:0] cof_sel;
  logic [CW-1:0] cof_abs;

  assign cof_sel = cof_r[{elem_idx[1:0], elem_idx[3:2]}];
  assign cof_abs = cof_sel[CW-1] ? CW'(-cof_sel) : CW'(cof_sel);
  assign den_abs = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
  assign rem_sh  = {rem_r, num_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, den_abs};
  assign div_done = (cnt_r == NW_C);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r  <= NW'(cof_abs) << (2 * FRAC_BITS);
      rem_r  <= '0;
      q_r    <= '0;
      cnt_r  <= '0;
      qneg_r <= cof_sel[CW-1] ^ det_r[DW-1];
    end else if (cmd.div_step && !div_done) begin
      num_r <= num_r << 1;
      cnt_r <= cnt_r + 1'b1;
      if (!rem_sub[DW]) begin
        rem_r <= rem_sub[DW-1:0];
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DW-1:0];
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
    end
  end

  // saturate and sign
  logic        q_big;
  logic [31:0] q_fin;
  assign q_big = (q_r[NW-1:31] != '0);
  always_comb begin
    if (det_r == '0) q_fin = '0;
    else if (qneg_r) q_fin = (q_big && q_r[NW-1:0] != NW'(32'h8000_0000))
                             ? 32'h8000_0000 : 32'(-q_r[31:0]);
    else q_fin = q_big ? 32'h7FFF_FFFF : q_r[31:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (elem_idx[1:0])
        2'd0: res0 <= q_fin;
        2'd1: res1 <= q_fin;
        2'd2: res2 <= q_fin;
        default: res3 <= q_fin;
      endcase
    end
  end

  assign sing = (det_r == '0);

endmodule

[tb/m4inv_checker.sv]
`timescale 1ns / 100ps

module m4inv_checker (
  input  logic        clk,
  input  logic        rst_n,
  m4inv_in_if         in_ch,
  m4inv_out_if        out_ch,
  output int          fail_cnt,
  output int          rows_pending,
  output int          rows_seen,
  output int          runs_seen,
  output int          singular_seen
);

  typedef struct packed {
    logic [1:0]         out_row;
    logic signed [31:0] e0;
    logic signed [31:0] e1;
    logic signed [31:0] e2;
    logic signed [31:0] e3;
    logic               singular;
    logic               last;
  } inv_row_t;

  typedef logic signed [255:0] wide_t;

  logic signed [31:0] mat[16];
  inv_row_t           inv_rows_q[$];

  // signed cofactor (i, j) of the stored matrix, exact
  function automatic wide_t cofactor_of(int i, int j);
    int    rs[3];
    int    cs[3];
    int    n;
    int    p[6][3];
    wide_t acc;
    wide_t a;
    wide_t b;
    wide_t c;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != i) begin rs[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != j) begin cs[n] = k; n++; end
    p = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2}, '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};
    acc = 0;
    for (int t = 0; t < 6; t++) begin
      a = mat[rs[0] * 4 + cs[p[t][0]]];
      b = mat[rs[1] * 4 + cs[p[t][1]]];
      c = mat[rs[2] * 4 + cs[p[t][2]]];
      // even permutations add, odd ones subtract
      if (t == 0 || t == 3 || t == 4) acc = acc + a * b * c;
      else acc = acc - a * b * c;
    end
    return ((i + j) % 2) ? -acc : acc;
  endfunction

  function automatic logic signed [31:0] scaled_div(wide_t cof, wide_t det);
    wide_t q;
    q = (cof <<< (2 * m4inv_pkg::FRAC_BITS_DEF)) / det;  // truncates toward zero
    if (q > wide_t'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
    if (q < -wide_t'(64'sh80000000)) return 32'sh80000000;
    return q[31:0];
  endfunction

  task automatic predict_inverse();
    wide_t            cof[16];
    wide_t            det;
    wide_t            m0;
    inv_row_t         r;
    logic signed [31:0] e[4];
    for (int i = 0; i < 16; i++) cof[i] = cofactor_of(i / 4, i % 4);
    det = 0;
    for (int c = 0; c < 4; c++) begin
      m0 = mat[c];
      det = det + cof[c] * m0;
    end
    for (int rr = 0; rr < 4; rr++) begin
      for (int c = 0; c < 4; c++)
        e[c] = (det == 0) ? 32'sd0 : scaled_div(cof[c * 4 + rr], det);
      r.out_row  = rr[1:0];
      r.e0       = e[0];
      r.e1       = e[1];
      r.e2       = e[2];
      r.e3       = e[3];
      r.singular = (det == 0);
      r.last     = (rr == 3);
      inv_rows_q.push_back(r);
    end
  endtask

  inv_row_t got;
  inv_row_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) mat[i] = '0;
      fail_cnt = 0;
      rows_seen = 0;
      runs_seen = 0;
      singular_seen = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_row, out_ch.out0, out_ch.out1, out_ch.out2, out_ch.out3,
                out_ch.singular, out_ch.last};
        rows_seen++;
        if (inv_rows_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected result row %p", got);
        end else begin
          want = inv_rows_q.pop_front();
          if (got !== want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("row mismatch at %0t\n  exp %p\n  got %p", $realtime, want, got);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        mat[in_ch.row_index * 4 + 0] = in_ch.col0;
        mat[in_ch.row_index * 4 + 1] = in_ch.col1;
        mat[in_ch.row_index * 4 + 2] = in_ch.col2;
        mat[in_ch.row_index * 4 + 3] = in_ch.col3;
        if (in_ch.row_index == 2'd3) begin
          predict_inverse();
          runs_seen++;
          if (inv_rows_q[inv_rows_q.size() - 1].singular) singular_seen++;
        end
      end
    end
    rows_pending = inv_rows_q.size();
  end

endmodule

[tb/matrix4x4_inverse_test.sv]
`timescale 1ns / 100ps

module matrix4x4_inverse_test;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int RANDOM_ITEMS = 390;
  localparam int LONG_HOLD = 8000;  // longer than one inversion run

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  m4inv_in_if  in_ch ();
  m4inv_out_if out_ch ();

  int fail_cnt;
  int rows_pending;
  int rows_seen;
  int runs_seen;
  int singular_seen;
  int cycle_cnt = 0;

  // idle control: no_idle is shared by sender and receiver, hold_req asks the receiver for a long hold-off
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  matrix4x4_inverse i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  m4inv_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_cnt      (fail_cnt),
    .rows_pending  (rows_pending),
    .rows_seen     (rows_seen),
    .runs_seen     (runs_seen),
    .singular_seen (singular_seen)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("matrix4x4_inverse_test NOT OK");
      $finish;
    end
  end

  // receiver: random stall per row, plus long hold-offs on request
  initial begin
    int stall;
    int hold;
    out_ch.ready = 1'b0;
    stall = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold == 0) begin
        hold = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      // redraw the stall once a row got through on the last edge
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) stall = no_idle ? 0 : $urandom_range(0, 17);
    end
  end

  // sender: one item per call, gap drawn per item
  task automatic send_row(input logic [1:0] idx, input logic signed [31:0] c0,
                          input logic signed [31:0] c1, input logic signed [31:0] c2,
                          input logic signed [31:0] c3);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.row_index <= idx;
    in_ch.col0      <= c0;
    in_ch.col1      <= c1;
    in_ch.col2      <= c2;
    in_ch.col3      <= c3;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // element mix: mostly modest Q16.16 values so that quotients stay in range
  function automatic logic signed [31:0] pick_elem();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 4)) - 2;  // tiny raw values
      default: return $signed($urandom_range(0, 1048575)) - 524288;
    endcase
  endfunction

  task automatic send_matrix(input logic signed [31:0] m[16]);
    for (int r = 0; r < 4; r++)
      send_row(r[1:0], m[r * 4], m[r * 4 + 1], m[r * 4 + 2], m[r * 4 + 3]);
  endtask

  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  initial begin
    logic signed [31:0] m[16];
    logic signed [31:0] e[4];
    int sent;
    int settle;

    in_ch.valid     = 1'b0;
    in_ch.row_index = '0;
    in_ch.col0      = '0;
    in_ch.col1      = '0;
    in_ch.col2      = '0;
    in_ch.col3      = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    // row 3 alone right after reset: rest of store is zero -> singular
    send_row(2'd3, ONE, ONE, ONE, ONE);
    // identity
    m = '{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE};
    send_matrix(m);
    // diagonal of raw 1 and -1: inverse saturates both ways
    m = '{1, 0, 0, 0, 0, -1, 0, 0, 0, 0, 1, 0, 0, 0, 0, -1};
    send_matrix(m);
    // extremes on the diagonal and off it
    m = '{32'sh80000000, 32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0,
          0, 0, 32'sh7FFFFFFF, -1, 0, 0, 32'sh80000000, 32'sh7FFFFFFF};
    send_matrix(m);
    // duplicate rows: singular
    m = '{ONE, 2 * ONE, 3, -4, ONE, 2 * ONE, 3, -4, 5, 6, 7, 8, 9, -10, 11, 12};
    send_matrix(m);
    // rows out of order, then row 3 reused with stale rows 0..2
    send_row(2'd2, 0, 0, 3 * ONE, 0);
    send_row(2'd0, 2 * ONE, 0, 0, ONE);
    send_row(2'd1, 0, -ONE, 0, 0);
    send_row(2'd3, ONE, 0, 0, ONE);
    send_row(2'd3, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);

    // random part: mostly whole matrices, some loose rows
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 7) == 0);
      if (sent > 120 && sent <= 124) hold_req = 1'b1;
      if ($urandom_range(0, 6) != 0) begin
        for (int i = 0; i < 16; i++) m[i] = pick_elem();
        // now and then force a dependent row
        if ($urandom_range(0, 7) == 0)
          for (int c = 0; c < 4; c++) m[12 + c] = m[$urandom_range(0, 2) * 4 + c];
        send_matrix(m);
        sent += 4;
      end else begin
        for (int c = 0; c < 4; c++) e[c] = pick_elem();
        send_row(2'($urandom_range(0, 3)), e[0], e[1], e[2], e[3]);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then a short settle for anything stray
    while (rows_pending != 0) @(posedge clk);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk);
      settle++;
    end

    $display("covered %0d inversion runs (%0d singular), %0d result rows checked",
             runs_seen, singular_seen, rows_seen);
    if (fail_cnt == 0) begin
      $display("matrix4x4_inverse_test OK");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("matrix4x4_inverse_test NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
src/m4inv_pkg.sv
src/m4inv_if.sv
src/m4inv_ctrl.sv
src/m4inv_dp.sv
src/matrix4x4_inverse.sv
tb/m4inv_checker.sv
tb/matrix4x4_inverse_test.sv
